// ===== src/lfpit_pkg.sv =====
package lfpit_pkg;

    localparam int TABLE_DEPTH_DEF = 32;
    localparam int ID_W            = 29;
    localparam int PAYLOAD_W       = 64;
    localparam int DROP_W          = 16;

    localparam logic [DROP_W-1:0] DROP_MAX = '1;

    typedef struct packed {
        logic [ID_W-1:0]      frame_id;
        logic [PAYLOAD_W-1:0] payload;
        logic                 flush;
    } frame_item_t;

    typedef struct packed {
        logic [ID_W-1:0]      entry_id;
        logic [PAYLOAD_W-1:0] entry_payload;
        logic                 is_ais;
        logic signed [7:0]    latitude;
        logic signed [7:0]    longitude;
        logic [31:0]          mmsi;
        logic [DROP_W-1:0]    dropped_count;
        logic                 last;
    } entry_item_t;

    // one table slot as seen by its neighbor
    typedef struct packed {
        logic                 valid;
        logic [ID_W-1:0]      id;
        logic [PAYLOAD_W-1:0] payload;
    } slot_t;

    // lookup token walking down the row
    typedef struct packed {
        logic                 valid;
        logic                 done;
        logic [ID_W-1:0]      id;
        logic [PAYLOAD_W-1:0] payload;
    } token_t;

    function automatic entry_item_t decode_slot(slot_t s, logic [DROP_W-1:0] drops,
                                                logic is_last);
        entry_item_t r;
        logic        ais;
        ais             = (s.id == '0);
        r.entry_id      = s.id;
        r.entry_payload = s.payload;
        r.is_ais        = ais;
        r.latitude      = ais ? signed'(s.payload[7:0]) : 8'sd0;
        r.longitude     = ais ? signed'(s.payload[15:8]) : 8'sd0;
        r.mmsi          = ais ? s.payload[47:16] : 32'd0;
        r.dropped_count = drops;
        r.last          = is_last;
        return r;
    endfunction

endpackage

// ===== src/lfpit_cell.sv =====
module lfpit_cell
    import lfpit_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  token_t tok_in,
    output token_t tok_out,
    input  logic   shift,
    input  slot_t  shift_in,
    output slot_t  slot
);

    logic                 valid_reg, valid_next;
    logic [ID_W-1:0]      id_reg, id_next;
    logic [PAYLOAD_W-1:0] payload_reg, payload_next;
    logic                 tok_valid_reg, tok_done_reg;
    logic [ID_W-1:0]      tok_id_reg;
    logic [PAYLOAD_W-1:0] tok_payload_reg;
    logic                 live, hit, claim;

    assign live  = tok_in.valid && !tok_in.done;
    assign hit   = live && valid_reg && (id_reg == tok_in.id);
    assign claim = live && !valid_reg;

    always_comb
    begin
        if (shift)
        begin
            valid_next   = shift_in.valid;
            id_next      = shift_in.id;
            payload_next = shift_in.payload;
        end
        else
        begin
            valid_next   = valid_reg | claim;
            id_next      = claim ? tok_in.id : id_reg;
            payload_next = (hit || claim) ? tok_in.payload : payload_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            tok_valid_reg <= tok_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg          <= id_next;
        payload_reg     <= payload_next;
        tok_done_reg    <= tok_in.done | hit | claim;
        tok_id_reg      <= tok_in.id;
        tok_payload_reg <= tok_in.payload;
    end

    assign slot    = '{valid: valid_reg, id: id_reg, payload: payload_reg};
    assign tok_out = '{valid: tok_valid_reg, done: tok_done_reg, id: tok_id_reg,
                       payload: tok_payload_reg};

endmodule

// ===== src/latest_frame_per_id_table_core.sv =====
// latest-value table for received frames, one slot per identifier in arrival order
//
// frame channel: frame_valid / frame_stall / frame. an item carries a 29-bit
// identifier, eight payload bytes and a flush flag. entry channel: entry_valid /
// entry_stall / entry, one item per held slot, emitted only after a flush frame.
//
// each accepted frame walks the row of TABLE_DEPTH cells, one cell per cycle,
// updating the matching slot or claiming the first free one; frame_stall
// stays high after each accept until the walk ends. a new identifier that finds
// the row full is dropped and counted (saturating at 65535).
// on flush the row shifts toward cell 0, one slot per cycle unless stalled, into
// the output register: N held slots give N entry items, back to back when not
// stalled, the first once the walk ends; the row and drop count are then empty.
//
// entry_stall holds a valid output item and then pauses the shift; the frame side
// stays stalled until the last entry item is loaded. a finished entry item may
// still wait while the next frame is taken.
// reset empties the row and the drop count; no clearing pass is needed.
module latest_frame_per_id_table_core
    import lfpit_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        frame_valid,
    output logic        frame_stall,
    input  frame_item_t frame,
    output logic        entry_valid,
    input  logic        entry_stall,
    output entry_item_t entry
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_EMIT   = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic              flush_reg, flush_next;
    logic [DROP_W-1:0] drop_reg, drop_next;
    logic              out_valid_reg, out_valid_next;
    entry_item_t       out_reg, out_next;

    token_t tok_chain [TABLE_DEPTH+1];
    slot_t  slots     [TABLE_DEPTH];
    slot_t  right     [TABLE_DEPTH];

    logic accept, load, shift, search_end;

    assign accept = frame_valid && !frame_stall;
    assign frame_stall = (state_reg != ST_IDLE);

    assign tok_chain[0] = '{valid: accept, done: 1'b0, id: frame.frame_id,
                            payload: frame.payload};

    genvar k;
    generate
        for (k = 0; k < TABLE_DEPTH; k++)
        begin : g_row
            if (k < TABLE_DEPTH - 1)
            begin : g_mid
                assign right[k] = slots[k+1];
            end
            else
            begin : g_end
                assign right[k] = '0;
            end

            lfpit_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .tok_in   (tok_chain[k]),
                .tok_out  (tok_chain[k+1]),
                .shift    (shift),
                .shift_in (right[k]),
                .slot     (slots[k])
            );
        end
    endgenerate

    assign search_end = (state_reg == ST_SEARCH) && tok_chain[TABLE_DEPTH].valid;
    assign load       = (state_reg == ST_EMIT) && (!out_valid_reg || !entry_stall);
    assign shift      = load;

    always_comb
    begin
        state_next     = state_reg;
        flush_next     = flush_reg;
        drop_next      = drop_reg;
        out_valid_next = out_valid_reg && entry_stall;
        out_next       = out_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    flush_next = frame.flush;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (search_end)
                begin
                    if (!tok_chain[TABLE_DEPTH].done && drop_reg != DROP_MAX)
                    begin
                        drop_next = drop_reg + DROP_W'(1);
                    end
                    state_next = flush_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    out_next       = decode_slot(slots[0], drop_reg, !right[0].valid);
                    if (!right[0].valid)
                    begin
                        drop_next  = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            flush_reg     <= 1'b0;
            drop_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            flush_reg     <= flush_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign entry_valid = out_valid_reg;
    assign entry       = out_reg;

endmodule

// ===== src/lfpit_checker.sv =====
module lfpit_checker
    import lfpit_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        frame_valid,
    input logic        frame_stall,
    input frame_item_t frame,
    input logic        entry_valid,
    input logic        entry_stall,
    input entry_item_t entry
);

    // stalled result item holds
    a_entry_hold: assert property (@(posedge clk) disable iff (!rst_n)
        entry_valid && entry_stall |=> entry_valid && $stable(entry))
        else $error("entry item changed while stalled");

    // an accepted frame is followed by frame_stall, as the block turns busy for its walk
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && !frame_stall |=> frame_stall)
        else $error("frame taken without search");

    a_ais_flag: assert property (@(posedge clk) disable iff (!rst_n)
        entry_valid |-> (entry.is_ais == (entry.entry_id == '0)))
        else $error("ais flag does not match identifier");

    a_ais_fields: assert property (@(posedge clk) disable iff (!rst_n)
        entry_valid && !entry.is_ais |->
            entry.latitude == 8'sd0 && entry.longitude == 8'sd0 && entry.mmsi == 32'd0)
        else $error("ais fields set on non-ais entry");

    a_ais_decode: assert property (@(posedge clk) disable iff (!rst_n)
        entry_valid && entry.is_ais |->
            entry.mmsi == entry.entry_payload[47:16] &&
            entry.latitude == signed'(entry.entry_payload[7:0]))
        else $error("ais decode mismatch");

endmodule

bind latest_frame_per_id_table_core lfpit_checker u_lfpit_checker (.*);

// ===== bench/testbench.sv =====
module testbench
    import lfpit_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH     = TABLE_DEPTH_DEF;
    localparam int RANDOM_ITEMS    = 400;
    localparam int WATCHDOG_CYCLES = 4000;
    localparam int N_DIRECTED      = 13;

    typedef struct packed {
        frame_item_t item;
        logic        pinned;
        entry_item_t want;
    } stim_row_t;

    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        '{'{29'd0, 64'hFFEE_DDCC_BBAA_807F, 1'b1}, 1'b1,
          '{29'd0, 64'hFFEE_DDCC_BBAA_807F, 1'b1, 8'sh7F, 8'sh80, 32'hDDCC_BBAA,
            16'd0, 1'b1}},
        '{'{29'h1FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1}, 1'b1,
          '{29'h1FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 8'sd0, 8'sd0, 32'd0,
            16'd0, 1'b1}},
        '{'{29'd0, 64'h0, 1'b1}, 1'b1,
          '{29'd0, 64'h0, 1'b1, 8'sd0, 8'sd0, 32'd0, 16'd0, 1'b1}},
        '{'{29'd1, 64'h1111_2222_3333_4444, 1'b0}, 1'b0, '0},
        '{'{29'd2, 64'h5555_6666_7777_8888, 1'b0}, 1'b0, '0},
        '{'{29'd1, 64'h9999_AAAA_BBBB_CCCC, 1'b0}, 1'b0, '0},
        '{'{29'd0, 64'h0000_8765_4321_FF01, 1'b0}, 1'b0, '0},
        '{'{29'h1555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0}, 1'b0, '0},
        '{'{29'h0AAA_AAAA, 64'h5555_5555_5555_5555, 1'b1}, 1'b0, '0},
        '{'{29'd5, 64'h0123_4567_89AB_CDEF, 1'b1}, 1'b1,
          '{29'd5, 64'h0123_4567_89AB_CDEF, 1'b0, 8'sd0, 8'sd0, 32'd0, 16'd0, 1'b1}},
        '{'{29'd0, 64'h8000_0000_0000_0001, 1'b0}, 1'b0, '0},
        '{'{29'd3, 64'hDEAD_BEEF_CAFE_F00D, 1'b0}, 1'b0, '0},
        '{'{29'd0, 64'h0000_7FFF_FFFF_80FF, 1'b1}, 1'b0, '0}
    };

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        frame_valid = 1'b0;
    logic        frame_stall;
    frame_item_t frame       = '0;
    logic        entry_valid;
    logic        entry_stall = 1'b0;
    entry_item_t entry;

    logic [ID_W-1:0]      row_ids      [TABLE_DEPTH];
    logic [PAYLOAD_W-1:0] row_payloads [TABLE_DEPTH];
    int                   held_count = 0;
    logic [DROP_W-1:0]    drop_tally = '0;
    entry_item_t          pending_entries [$];

    int          mismatches  = 0;
    int          idle_cycles = 0;
    int          stall_run   = 0;
    int          stall_pick;
    bit          calm        = 1'b0;
    entry_item_t want;

    latest_frame_per_id_table_core #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame       (frame),
        .entry_valid (entry_valid),
        .entry_stall (entry_stall),
        .entry       (entry)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic absorb_frame(input frame_item_t f, input logic pinned,
                                input entry_item_t pin_entry);
        int                   slot;
        logic                 ais;
        logic [PAYLOAD_W-1:0] p;
        entry_item_t          e;
        slot = -1;
        for (int i = 0; i < held_count; i++)
        begin
            if (slot < 0 && row_ids[i] == f.frame_id)
                slot = i;
        end
        if (slot >= 0)
            row_payloads[slot] = f.payload;
        else if (held_count < TABLE_DEPTH)
        begin
            row_ids[held_count]      = f.frame_id;
            row_payloads[held_count] = f.payload;
            held_count++;
        end
        else if (drop_tally != DROP_MAX)
            drop_tally++;
        if (f.flush)
        begin
            for (int i = 0; i < held_count; i++)
            begin
                p               = row_payloads[i];
                ais             = (row_ids[i] == '0);
                e.entry_id      = row_ids[i];
                e.entry_payload = p;
                e.is_ais        = ais;
                e.latitude      = ais ? p[7:0] : 8'h00;
                e.longitude     = ais ? p[15:8] : 8'h00;
                e.mmsi          = ais ? {p[47:40], p[39:32], p[31:24], p[23:16]} : 32'd0;
                e.dropped_count = drop_tally;
                e.last          = (i == held_count - 1);
                if (!pinned)
                    pending_entries.push_back(e);
            end
            if (pinned)
                pending_entries.push_back(pin_entry);
            held_count = 0;
            drop_tally = '0;
        end
    endtask

    task automatic push_frame(input frame_item_t f, input int gap, input logic pinned,
                              input entry_item_t pin_entry);
        if (gap > 0)
        begin
            frame_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        frame_valid <= 1'b1;
        frame       <= f;
        @(posedge clk);
        while (frame_stall) @(posedge clk);
        absorb_frame(f, pinned, pin_entry);
    endtask

    task automatic wait_for_drain();
        frame_valid <= 1'b0;
        @(posedge clk);
        while (pending_entries.size() != 0) @(posedge clk);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [ID_W-1:0] pick_id(input bit fresh);
        logic [ID_W-1:0] id;
        id = ID_W'($urandom);
        if (!fresh && $urandom_range(0, 1) == 0)
        begin
            case ($urandom_range(0, 5))
                0, 1:    id = '0;
                2:       id = '1;
                default: id = ID_W'($urandom_range(1, 4));
            endcase
        end
        return id;
    endfunction

    task automatic check_field(input string name, input logic [63:0] exp,
                               input logic [63:0] act);
        if (exp !== act)
        begin
            $error("%s: expected %0h, got %0h", name, exp, act);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_run > 0)
            stall_run--;
        else if (calm)
            entry_stall <= 1'b0;
        else
        begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 60)
            begin
                entry_stall <= 1'b0;
                stall_run = $urandom_range(0, 4);
            end
            else if (stall_pick < 93)
            begin
                entry_stall <= 1'b1;
                stall_run = $urandom_range(0, 3);
            end
            else
            begin
                entry_stall <= 1'b1;
                stall_run = $urandom_range(10, 50);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && entry_valid && !entry_stall)
        begin
            if (pending_entries.size() == 0)
            begin
                $error("unexpected entry item, entry_id %0h", entry.entry_id);
                mismatches++;
            end
            else
            begin
                want = pending_entries.pop_front();
                check_field("entry_id", want.entry_id, entry.entry_id);
                check_field("entry_payload", want.entry_payload, entry.entry_payload);
                check_field("is_ais", want.is_ais, entry.is_ais);
                check_field("latitude", $unsigned(want.latitude), $unsigned(entry.latitude));
                check_field("longitude", $unsigned(want.longitude),
                            $unsigned(entry.longitude));
                check_field("mmsi", want.mmsi, entry.mmsi);
                check_field("dropped_count", want.dropped_count, entry.dropped_count);
                check_field("last", want.last, entry.last);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((frame_valid && !frame_stall) || (entry_valid && !entry_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_CYCLES)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        frame_item_t f;
        int          sent;
        int          len;
        bit          fill;
        sent = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        for (int n = 0; n < N_DIRECTED; n++)
            push_frame(DIRECTED[n].item, pick_gap(), DIRECTED[n].pinned, DIRECTED[n].want);
        wait_for_drain();

        for (int burst = 0; sent < RANDOM_ITEMS; burst++)
        begin
            fill = (burst < 3) || ($urandom_range(0, 99) < 12);
            len  = fill ? $urandom_range(TABLE_DEPTH + 1, TABLE_DEPTH + 6)
                        : $urandom_range(1, 8);
            calm = ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 9) == 0)
                wait_for_drain();
            for (int k = 0; k < len; k++)
            begin
                f.frame_id = pick_id(fill && $urandom_range(0, 3) != 0);
                f.payload  = {$urandom, $urandom};
                // occasional stray flush mid-burst or missing flush at the end
                f.flush    = (k == len - 1) ^ ($urandom_range(0, 29) == 0);
                push_frame(f, pick_gap(), 1'b0, '0);
                sent++;
            end
        end
        // make sure the last frames are emitted
        f.frame_id = pick_id(1'b0);
        f.payload  = {$urandom, $urandom};
        f.flush    = 1'b1;
        push_frame(f, pick_gap(), 1'b0, '0);

        wait_for_drain();
        calm = 1'b1;
        repeat (2 * TABLE_DEPTH + 10) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
